// File: src/multi_deque_with_top_swap_macros.svh
// Assertion macros used by the checker file of the deque block.
`ifndef MULTI_DEQUE_WITH_TOP_SWAP_MACROS_SVH
`define MULTI_DEQUE_WITH_TOP_SWAP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define MDQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define MDQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/mdq_pkg.sv
// Package of the deque block: sizes, codes, state type and helper functions.
`default_nettype none

package mdq_pkg;

   localparam int NUM_QUEUES  = 4;
   localparam int QUEUE_DEPTH = 1024;

   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int QIN_W    = 2;
   localparam int STATUS_W = 2;
   localparam int QSEL_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W   = $clog2(STORE_DEPTH);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_SWAP  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_DATA,
      ST_SWAP_B,
      ST_SWAP_W1,
      ST_SWAP_W2
   } state_type;

   // Per-queue pointer update from the controller
   typedef struct packed {
      logic              we;
      logic [QSEL_W-1:0] q;
      logic [PTR_W-1:0]  front;
      logic [CNT_W-1:0]  count;
   } meta_upd_type;

   // Queue selector folded into range by repeated subtraction
   function automatic logic [QSEL_W-1:0] queue_sel(input logic [QIN_W-1:0] w);
      logic [QIN_W-1:0] r;
      r = w;
      for (int i = 0; i < 3; i++) begin
         if (int'(r) >= NUM_QUEUES) r = r - QIN_W'(NUM_QUEUES);
      end
      return QSEL_W'(r);
   endfunction

   // Ring position wrap: input is below twice the depth
   function automatic logic [PTR_W-1:0] pos_wrap(input logic [CNT_W:0] s);
      logic [CNT_W:0] r;
      if (s >= (CNT_W+1)'(QUEUE_DEPTH)) r = s - (CNT_W+1)'(QUEUE_DEPTH);
      else r = s;
      return PTR_W'(r);
   endfunction

   // Element store address of a ring position within a queue's region
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [QSEL_W-1:0] q,
                                                   input logic [PTR_W-1:0] pos);
      return ADDR_W'(ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(pos);
   endfunction

endpackage

`default_nettype wire

// File: src/mdq_ram.sv
// Generic RAM: one write port, one read port with registered read data.
`default_nettype none

module mdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // Read port with registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/mdq_meta.sv
// Front index and element count of every queue, cleared by reset.
`default_nettype none

module mdq_meta
   import mdq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [QSEL_W-1:0] rd_q,
   output logic      [PTR_W-1:0]  rd_front,
   output logic      [CNT_W-1:0]  rd_count,
   input  wire meta_upd_type      upd
);

   logic [PTR_W-1:0] front_ff [NUM_QUEUES];
   logic [CNT_W-1:0] count_ff [NUM_QUEUES];

   // Pointer update for the addressed queue
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            front_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else if (upd.we) begin
         front_ff[upd.q] <= upd.front;
         count_ff[upd.q] <= upd.count;
      end
   end

   assign rd_front = front_ff[rd_q];
   assign rd_count = count_ff[rd_q];

endmodule

`default_nettype wire

// File: src/mdq_ctrl.sv
// Request sequencer: pointer arithmetic, element store access and result register.
`default_nettype none

module mdq_ctrl
   import mdq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [OP_W-1:0]          req_op,
   input  wire logic [QIN_W-1:0]         req_which_queue,
   input  wire logic                     req_at_back,
   input  wire logic signed [DATA_W-1:0] req_value,
   // result channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [DATA_W-1:0]      rsp_popped,
   // queue pointers
   output logic [QSEL_W-1:0]             meta_q,
   input  wire logic [PTR_W-1:0]         cur_front,
   input  wire logic [CNT_W-1:0]         cur_count,
   output meta_upd_type                  meta_upd,
   // element store
   output logic                          ram_we,
   output logic [ADDR_W-1:0]             ram_waddr,
   output logic [DATA_W-1:0]             ram_wdata,
   output logic [ADDR_W-1:0]             ram_raddr,
   input  wire logic [DATA_W-1:0]        ram_rd_data
);

   state_type                  state_ff, state_in;
   logic [ADDR_W-1:0]          addr_a_ff, addr_a_in;
   logic [ADDR_W-1:0]          addr_b_ff, addr_b_in;
   logic [DATA_W-1:0]          hold_ff, hold_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0]   rsp_popped_ff, rsp_popped_in;

   logic                       accept;
   logic                       load_rsp;
   logic [QSEL_W-1:0]          q_sel;
   logic [CNT_W:0]             end_sum;
   logic [PTR_W-1:0]           front_dec, front_inc, back_push_pos, back_pop_pos;
   logic                       is_full, is_empty, too_few;

   // Pointer arithmetic for the addressed queue
   always_comb begin
      q_sel    = queue_sel(req_which_queue);
      end_sum  = (CNT_W+1)'(cur_front) + (CNT_W+1)'(cur_count);
      back_push_pos = pos_wrap(end_sum);
      back_pop_pos  = pos_wrap(end_sum - (CNT_W+1)'(1));
      front_dec = (cur_front == '0) ? PTR_W'(QUEUE_DEPTH - 1) : cur_front - PTR_W'(1);
      front_inc = (cur_front == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_front + PTR_W'(1);
      is_full  = (cur_count == CNT_W'(QUEUE_DEPTH));
      is_empty = (cur_count == '0);
      too_few  = (cur_count < CNT_W'(2));
   end

   assign meta_q = q_sel;
   assign accept = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op_type'(req_op) == OP_POP && !is_empty) state_in = ST_POP_DATA;
               else if (op_type'(req_op) == OP_SWAP && !too_few) state_in = ST_SWAP_B;
            end
         end
         ST_POP_DATA: state_in = ST_IDLE;
         ST_SWAP_B:   state_in = ST_SWAP_W1;
         ST_SWAP_W1:  state_in = ST_SWAP_W2;
         ST_SWAP_W2:  state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs per state
   always_comb begin
      req_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = addr_a_ff;
      ram_wdata     = hold_ff;
      ram_raddr     = addr_b_ff;
      meta_upd.we    = 1'b0;
      meta_upd.q     = q_sel;
      meta_upd.front = cur_front;
      meta_upd.count = cur_count;
      load_rsp      = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_popped_in = '0;
      addr_a_in     = addr_a_ff;
      addr_b_in     = addr_b_ff;
      hold_in       = hold_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            ram_raddr = (op_type'(req_op) == OP_POP && req_at_back)
                        ? slot_addr(q_sel, back_pop_pos) : slot_addr(q_sel, cur_front);
            addr_a_in = slot_addr(q_sel, cur_front);
            addr_b_in = slot_addr(q_sel, front_inc);
            if (accept) begin
               unique case (op_type'(req_op))
                  OP_PUSH: begin
                     load_rsp = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = req_at_back ? slot_addr(q_sel, back_push_pos)
                                                : slot_addr(q_sel, front_dec);
                        ram_wdata = req_value;
                        meta_upd.we    = 1'b1;
                        meta_upd.front = req_at_back ? cur_front : front_dec;
                        meta_upd.count = cur_count + CNT_W'(1);
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        load_rsp      = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        meta_upd.we    = 1'b1;
                        meta_upd.front = req_at_back ? cur_front : front_inc;
                        meta_upd.count = cur_count - CNT_W'(1);
                     end
                  end
                  OP_SWAP: begin
                     if (too_few) begin
                        load_rsp      = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end
                  end
                  OP_CLEAR: begin
                     load_rsp       = 1'b1;
                     meta_upd.we    = 1'b1;
                     meta_upd.front = '0;
                     meta_upd.count = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_POP_DATA: begin
            load_rsp      = 1'b1;
            rsp_popped_in = signed'(ram_rd_data);
         end
         ST_SWAP_B: begin
            // first front word arrives, second is being read
            ram_raddr = addr_b_ff;
            hold_in   = ram_rd_data;
         end
         ST_SWAP_W1: begin
            ram_we    = 1'b1;
            ram_waddr = addr_a_ff;
            ram_wdata = ram_rd_data;
         end
         ST_SWAP_W2: begin
            ram_we    = 1'b1;
            ram_waddr = addr_b_ff;
            ram_wdata = hold_ff;
            load_rsp  = 1'b1;
         end
         default: ;
      endcase
   end

   // Result register: filled on completion, emptied when taken
   always_comb begin
      if (load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_a_ff <= addr_a_in;
      addr_b_ff <= addr_b_in;
      hold_ff   <= hold_in;
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_popped_ff <= rsp_popped_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_popped = rsp_popped_ff;

endmodule

`default_nettype wire

// File: src/multi_deque_with_top_swap.sv
// Top level of the multi-queue deque block with front swap.
`default_nettype none

// Several bounded double-ended queues of signed 32-bit words share one element
// memory, each queue a ring of QUEUE_DEPTH entries with its front index and
// count held in flip-flops. One request is handled at a time and each yields
// one item on the result channel. Push, clear and every rejected request
// complete when accepted; a pop waits on the registered memory read; a swap
// does two reads then two writes through the single write port of the element
// memory. The result register lets a new item in while the previous result
// is being taken. The element memory needs no clearing pass after reset:
// only held elements are ever read.
module multi_deque_with_top_swap
   import mdq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [OP_W-1:0]          req_op,
   input  wire logic [QIN_W-1:0]         req_which_queue,
   input  wire logic                     req_at_back,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [DATA_W-1:0]      rsp_popped
);

   logic [QSEL_W-1:0] meta_q;
   logic [PTR_W-1:0]  cur_front;
   logic [CNT_W-1:0]  cur_count;
   meta_upd_type      meta_upd;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rd_data;

   mdq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_which_queue (req_which_queue),
      .req_at_back     (req_at_back),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_popped      (rsp_popped),
      .meta_q          (meta_q),
      .cur_front       (cur_front),
      .cur_count       (cur_count),
      .meta_upd        (meta_upd),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .ram_raddr       (ram_raddr),
      .ram_rd_data     (ram_rd_data)
   );

   mdq_meta u_meta (
      .clock    (clock),
      .reset    (reset),
      .rd_q     (meta_q),
      .rd_front (cur_front),
      .rd_count (cur_count),
      .upd      (meta_upd)
   );

   mdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// File: src/mdq_checker.sv
// Port-level checker of the deque block, bound to the top level.
`default_nettype none
`include "multi_deque_with_top_swap_macros.svh"

module mdq_checker
   import mdq_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic [OP_W-1:0]          req_op,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [STATUS_W-1:0]      rsp_status,
   input wire logic signed [DATA_W-1:0] rsp_popped
);

   // A result that is not taken stays put
   `MDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_popped), "result changed while stalled")

   // Rejected requests carry a zero word
   `MDQ_ASSERT_NOW(a_err_zero, rsp_valid && rsp_status != STATUS_OK, rsp_popped == '0, "error result with non-zero word")

   // No new item while an untaken result blocks the result register
   `MDQ_ASSERT_NOW(a_ready_gate, req_ready && rsp_valid, rsp_ready, "ready while result register full")

   // Clear result is valid in the next cycle with status ok
   `MDQ_ASSERT_NEXT(a_clear_fast, req_valid && req_ready && req_op == OP_CLEAR, rsp_valid && rsp_status == STATUS_OK, "clear result missing")

endmodule

bind multi_deque_with_top_swap mdq_checker u_checker (.*);

`default_nettype wire
